FILE: rtl/cfts_pkg.sv
// -----------------------------------------------------------------------------
// cfts_pkg: shared types and constants of the camera and flash trigger sequencer
// Holds the item layouts, the configuration and state records, register
// indexes and the light mask helper.
// -----------------------------------------------------------------------------
package cfts_pkg;

    // Highest number of flash lights the block can address.
    localparam int MAX_LIGHTS = 8;
    localparam int MASK_W     = 8;

    // Effective light limit: the masks are eight bits wide whatever the limit.
    localparam logic [3:0] LIGHT_LIMIT = 4'((MAX_LIGHTS < MASK_W) ? MAX_LIGHTS : MASK_W);

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_SIM_ENABLE        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SIM_ABSENT_LIGHTS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIM_ABSENT_CAMERA = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SIM_DELAY_TICKS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_COUNT       = 3'd4;

    // Auto-settings handshake states.
    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_STARTED  = 2'd1,
        SEQ_WAIT_END = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic        sim_enable;
        logic        sim_absent_lights;
        logic        sim_absent_camera;
        logic [15:0] sim_delay_ticks;
        logic [3:0]  light_count;
    } cfg_t;

    // Input item, last member in the lowest bits.
    typedef struct packed {
        logic               search_request;
        logic               trigger_request;
        logic [7:0]         light_ready_mask;
        logic [7:0]         light_ok_mask;
        logic signed [31:0] cam_image_time;
        logic [31:0]        cam_accept_count;
        logic               cam_acq_ready;
        logic               cam_module_ok;
    } in_item_t;

    // Result item, last member in the lowest bits.
    typedef struct packed {
        logic [31:0] image_total;
        logic [31:0] trigger_total;
        logic        trigger_pending;
        logic        search_done;
        logic [7:0]  flash_trigger_mask;
        logic        cam_search_cmd;
        logic        cam_acquire_cmd;
        logic        new_image;
        logic        busy_res;
        logic        hw_error;
        logic        block_ready;
    } out_item_t;

    localparam int IN_ITEM_W   = $bits(in_item_t);
    localparam int OUT_ITEM_W  = $bits(out_item_t);
    localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

    // Sequencer state carried from one item to the next (counters excepted).
    typedef struct packed {
        seq_state_t  seq;
        logic        trigger_active;
        logic        pending_trigger;
        logic        waiting_image;
        logic [31:0] prev_accept_count;
        logic [31:0] prev_image_time;
        logic [15:0] delay_elapsed;
        logic        acquire;
        logic        search;
        logic [7:0]  flash;
        logic        done;
        logic        busy;
    } core_state_t;

    // Mask of the lights in use, with the count saturated at the limit.
    function automatic logic [7:0] light_mask(input logic [3:0] count);
        logic [3:0] n;
        logic [8:0] m;
        n = (count > LIGHT_LIMIT) ? LIGHT_LIMIT : count;
        m = (9'd1 << n) - 9'd1;
        return m[7:0];
    endfunction

endpackage

FILE: rtl/cfts_cfg.sv
// -----------------------------------------------------------------------------
// cfts_cfg: configuration registers
// Decodes the write port and holds the five settings of the sequencer.
// -----------------------------------------------------------------------------
module cfts_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cfts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cfts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output cfts_pkg::cfg_t                    cfg
);

    cfts_pkg::cfg_t cfg_reg;
    cfts_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                cfts_pkg::REG_SIM_ENABLE:        cfg_next.sim_enable        = cfg_wdata[0];
                cfts_pkg::REG_SIM_ABSENT_LIGHTS: cfg_next.sim_absent_lights = cfg_wdata[0];
                cfts_pkg::REG_SIM_ABSENT_CAMERA: cfg_next.sim_absent_camera = cfg_wdata[0];
                cfts_pkg::REG_SIM_DELAY_TICKS:   cfg_next.sim_delay_ticks   = cfg_wdata[15:0];
                cfts_pkg::REG_LIGHT_COUNT:       cfg_next.light_count       = cfg_wdata[3:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/cfts_step.sv
// -----------------------------------------------------------------------------
// cfts_step: per-tick decision logic
// From the held input item, the settings and the current state, works out the
// next state, the next counters and the result item of one scan tick.
// -----------------------------------------------------------------------------
module cfts_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  cfts_pkg::cfg_t           cfg,
    input  cfts_pkg::in_item_t       item,
    input  cfts_pkg::core_state_t    st,
    input  logic [COUNT_WIDTH-1:0]   trig_cnt,
    input  logic [COUNT_WIDTH-1:0]   img_cnt,
    output cfts_pkg::core_state_t    st_nx,
    output logic [COUNT_WIDTH-1:0]   trig_cnt_nx,
    output logic [COUNT_WIDTH-1:0]   img_cnt_nx,
    output cfts_pkg::out_item_t      result
);

    logic        sim;
    logic        cam_down;
    logic        cam_simulated;
    logic [7:0]  lmask;
    logic        light_ok;
    logic        light_ready;
    logic        hw_err;
    logic        ready;
    logic [31:0] pac_base;
    logic [31:0] pac_eff;
    logic [31:0] pit_eff;
    logic        accept_seen;
    logic        image_changed;
    logic        timer_run;
    logic        timer_due;
    logic        new_img;

    assign sim           = cfg.sim_enable;
    assign cam_down      = !item.cam_module_ok && !sim;
    assign cam_simulated = !item.cam_module_ok && cfg.sim_absent_camera;
    assign lmask         = cfts_pkg::light_mask(cfg.light_count);

    // A light that is not ok counts as failed and not ready unless absent
    // lights are ignored; an ok light that is not ready only blocks readiness.
    assign light_ok    = cfg.sim_absent_lights || ((lmask & ~item.light_ok_mask) == 8'd0);
    assign light_ready = light_ok
                         && ((lmask & item.light_ok_mask & ~item.light_ready_mask) == 8'd0);

    assign hw_err = !sim && (!light_ok || (!item.cam_module_ok && !cfg.sim_absent_camera));
    assign ready  = sim ? !st.trigger_active
                        : (!hw_err && (item.cam_acq_ready || cam_simulated)
                           && light_ready && !st.trigger_active);

    // A camera that is down forgets its history; simulation fakes an accept.
    assign pac_base      = cam_down ? 32'd0 : st.prev_accept_count;
    assign pac_eff       = (st.trigger_active && sim) ? pac_base + 32'd1 : pac_base;
    assign pit_eff       = cam_down ? 32'd0 : st.prev_image_time;
    assign accept_seen   = pac_eff != item.cam_accept_count;
    assign image_changed = pit_eff != $unsigned(item.cam_image_time);

    always_comb
    begin
        st_nx       = st;
        trig_cnt_nx = trig_cnt;
        img_cnt_nx  = img_cnt;
        timer_run   = 1'b0;
        timer_due   = 1'b0;
        new_img     = 1'b0;

        if (item.trigger_request)
        begin
            st_nx.pending_trigger = 1'b1;
        end

        if (!item.search_request && st.done)
        begin
            st_nx.search = 1'b0;
            st_nx.done   = 1'b0;
        end

        case (st.seq)
            cfts_pkg::SEQ_IDLE:
            begin
                if (ready)
                begin
                    if (st_nx.pending_trigger)
                    begin
                        st_nx.trigger_active  = 1'b1;
                        st_nx.pending_trigger = 1'b0;
                        st_nx.busy            = 1'b1;
                        st_nx.acquire         = 1'b1;
                        st_nx.flash           = st.flash | lmask;
                    end
                    else if (item.search_request)
                    begin
                        st_nx.search  = 1'b1;
                        st_nx.acquire = 1'b1;
                        st_nx.seq     = cfts_pkg::SEQ_STARTED;
                    end
                end
            end
            cfts_pkg::SEQ_STARTED:
            begin
                if (!ready)
                begin
                    st_nx.seq = cfts_pkg::SEQ_WAIT_END;
                end
            end
            cfts_pkg::SEQ_WAIT_END:
            begin
                if (ready)
                begin
                    st_nx.done = 1'b1;
                    st_nx.seq  = cfts_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                st_nx.seq = st.seq;
            end
        endcase

        if (accept_seen)
        begin
            st_nx.trigger_active = 1'b0;
            trig_cnt_nx          = trig_cnt + 1'b1;
            st_nx.waiting_image  = 1'b1;
            st_nx.acquire        = 1'b0;
            st_nx.flash          = st_nx.flash & ~lmask;
        end

        // Simulated image delay, saturating at the programmed tick count.
        timer_run = (sim || cam_simulated) && st_nx.waiting_image;
        if (!timer_run)
        begin
            st_nx.delay_elapsed = 16'd0;
        end
        else
        begin
            timer_due = st.delay_elapsed >= cfg.sim_delay_ticks;
            if (!timer_due)
            begin
                st_nx.delay_elapsed = st.delay_elapsed + 16'd1;
            end
        end

        new_img = image_changed || timer_due;
        if (new_img)
        begin
            st_nx.waiting_image = 1'b0;
            st_nx.busy          = 1'b0;
            img_cnt_nx          = img_cnt + 1'b1;
        end

        st_nx.prev_accept_count = item.cam_accept_count;
        st_nx.prev_image_time   = $unsigned(item.cam_image_time);
    end

    always_comb
    begin
        result.block_ready        = ready;
        result.hw_error           = hw_err;
        result.busy_res           = st_nx.busy;
        result.new_image          = new_img;
        result.cam_acquire_cmd    = st_nx.acquire;
        result.cam_search_cmd     = st_nx.search;
        result.flash_trigger_mask = st_nx.flash;
        result.search_done        = st_nx.done;
        result.trigger_pending    = st_nx.pending_trigger;
        result.trigger_total      = 32'(trig_cnt_nx);
        result.image_total        = 32'(img_cnt_nx);
    end

endmodule

FILE: rtl/camera_flash_trigger_sequencer.sv
// -----------------------------------------------------------------------------
// camera_flash_trigger_sequencer: camera and flash light trigger sequencing
// Scan-tick driven sequencer for one camera and up to eight flash lights.
// -----------------------------------------------------------------------------
// Usage
// Each item on the slave stream is one scan tick: camera health, readiness,
// accepted-acquisition count and image timestamp, the per-light ok and ready
// masks, a trigger request and a level auto-settings search request. For
// every input item exactly one result item leaves on the master stream with
// the ready and error flags, the camera and flash commands, the search
// handshake status and the running trigger and image totals.
// An accepted input item passes through the input register and then through
// the decision logic into the result register. The sequencer state is a single
// register set updated once per tick, so one item per cycle is sustained while
// the receiver keeps taking results; the recurrence through that state is what
// fixes the rate at one item a cycle.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more; the slave side then deasserts tready until the
// result is taken. Reset clears the settings, all sequencer state and both
// counters, and empties both registers. The user must write settings through
// the configuration port only while no item is in flight; it is not enforced.
// -----------------------------------------------------------------------------
module camera_flash_trigger_sequencer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [cfts_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cfts_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0 up: cam_module_ok, cam_acq_ready, cam_accept_count[32],
    // cam_image_time[32], light_ok_mask[8], light_ready_mask[8],
    // trigger_request, search_request, zero fill.
    input  logic [cfts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0 up: block_ready, hw_error, busy_res, new_image,
    // cam_acquire_cmd, cam_search_cmd, flash_trigger_mask[8], search_done,
    // trigger_pending, trigger_total[32], image_total[32].
    output logic [cfts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    cfts_pkg::cfg_t           cfg;

    // Input register.
    logic                     in_valid_reg;
    logic                     in_valid_next;
    cfts_pkg::in_item_t       in_reg;

    // Sequencer state and counters.
    cfts_pkg::core_state_t    st_reg;
    cfts_pkg::core_state_t    st_next;
    logic [COUNT_WIDTH-1:0]   trig_cnt_reg;
    logic [COUNT_WIDTH-1:0]   trig_cnt_next;
    logic [COUNT_WIDTH-1:0]   img_cnt_reg;
    logic [COUNT_WIDTH-1:0]   img_cnt_next;

    // Result register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    cfts_pkg::out_item_t      out_reg;
    cfts_pkg::out_item_t      out_next;

    logic                     s_accept;
    logic                     advance;

    cfts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cfts_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cfg         (cfg),
        .item        (in_reg),
        .st          (st_reg),
        .trig_cnt    (trig_cnt_reg),
        .img_cnt     (img_cnt_reg),
        .st_nx       (st_next),
        .trig_cnt_nx (trig_cnt_next),
        .img_cnt_nx  (img_cnt_next),
        .result      (out_next)
    );

    // The held item moves on whenever the result register is free or is being
    // emptied in the same cycle; the state advances with it.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{seq: cfts_pkg::SEQ_IDLE, default: '0};
            trig_cnt_reg  <= '0;
            img_cnt_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg       <= st_next;
                trig_cnt_reg <= trig_cnt_next;
                img_cnt_reg  <= img_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_reg <= cfts_pkg::in_item_t'(s_axis_tdata[cfts_pkg::IN_ITEM_W-1:0]);
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = cfts_pkg::OUT_TDATA_W'(out_reg);

`ifndef SYNTHESIS
    // The slave side only stalls while both registers are full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // A held item that cannot move on stays put until it can.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("held input item lost or changed");

    // An active trigger always has the acquire command raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.trigger_active |-> st_reg.acquire)
        else $error("trigger active without acquire command");

    // A result item that is refused stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result item dropped or changed while stalled");
`endif

endmodule
